/* src/rmid_pkg.sv */
package rmid_pkg;

	// Number of cells in the sorted row.
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic               action;
		logic signed [31:0] value;
	} req_word_t;

	typedef struct packed {
		logic signed [32:0] median_twice;
		logic               median_valid;
		logic [6:0]         element_count;
		logic [1:0]         status;
	} rsp_word_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage

/* src/rmid_cell.sv */
module rmid_cell (
	input  logic               clk,
	input  rmid_pkg::cell_cmd_t cmd,
	input  logic               in_use,
	input  logic signed [31:0] left_value,
	input  logic               left_le,
	input  logic signed [31:0] right_value,
	output logic signed [31:0] value,
	output logic               le,
	output logic               eq
);
	import rmid_pkg::*;

	logic signed [31:0] value_q;
	logic               lt;

	assign value = value_q;
	assign le    = in_use && (value_q <= cmd.value);
	assign lt    = in_use && (value_q < cmd.value);
	assign eq    = in_use && (value_q == cmd.value);

	// Insert: cells past the insertion point shift right, the first of them takes
	// the new value. Remove: cells from the first match on shift left.
	always_ff @(posedge clk) begin
		if (cmd.ins && !le) begin
			value_q <= left_le ? cmd.value : left_value;
		end else if (cmd.rem && !lt) begin
			value_q <= right_value;
		end
	end

endmodule

/* src/running_median_insert_delete_top.sv */
// Running median over a sorted multiset of signed 32-bit values.
//
// The req channel carries one word per step: an action (insert or remove one
// occurrence) and a value. The rsp channel returns exactly one word per req
// word: twice the median (lower plus upper middle element), a flag that the
// store is non-empty, the element count after the step, and a status code.
//
// The values sit in a row of CAPACITY cells kept in ascending order. Every
// cell compares its value with the request in parallel and takes its own,
// its left or its right neighbor's value, so the whole row updates at once.
// The median step then selects the two middle cells by the count and adds them.
// A new request enters only once the previous one has left the row update;
// it may enter while the median of that one is written out.
//
// Reset empties the store (count zero) and clears all handshake state.
// When the receiver stalls, the result holds in the output register; the
// next request may still enter and update the row, and the block stalls req
// only once that request's median waits for the output register.
module running_median_insert_delete_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rmid_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rmid_pkg::rsp_word_t rsp
);
	import rmid_pkg::*;

	logic             s1_q;
	logic             s2_q;
	req_word_t        item_s1;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       status_q;

	logic signed [31:0]  cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_le;
	logic [CAPACITY-1:0] cell_eq;
	logic [CAPACITY-1:0] in_use;
	cell_cmd_t           cmd;

	logic             out_free;
	logic             req_accept;
	logic             found;
	logic             full;
	logic [IDX_W-1:0] idx_lo;
	logic [IDX_W-1:0] idx_hi;
	logic signed [32:0] median_sum;

	// The output register is free when empty or being drained this cycle.
	assign out_free   = !rsp_valid || !rsp_stall;
	// One request in flight: no new one while the row updates or while the
	// median of the previous one cannot be written out.
	assign req_stall  = s1_q || (s2_q && !out_free);
	assign req_accept = req_valid && !req_stall;

	assign found = |cell_eq;
	assign full  = (count_q >= CNT_W'(CAPACITY));

	assign cmd.value = item_s1.value;
	assign cmd.ins   = s1_q && (item_s1.action == ACT_INSERT) && !full;
	assign cmd.rem   = s1_q && (item_s1.action == ACT_REMOVE) && found;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_value;
		logic               left_le;
		logic signed [31:0] right_value;

		assign in_use[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_value = item_s1.value;
			assign left_le    = 1'b1;
		end else begin : g_inner
			assign left_value = cell_value[i-1];
			assign left_le    = cell_le[i-1];
		end

		// The last cell has no right neighbor; it lies beyond the count after
		// a removal, so whatever it keeps is never read.
		if (i == CAPACITY - 1) begin : g_last
			assign right_value = cell_value[i];
		end else begin : g_mid
			assign right_value = cell_value[i+1];
		end

		rmid_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.in_use      (in_use[i]),
			.left_value  (left_value),
			.left_le     (left_le),
			.right_value (right_value),
			.value       (cell_value[i]),
			.le          (cell_le[i]),
			.eq          (cell_eq[i])
		);
	end

	// Middle positions for the count after the update. With an empty store
	// the indices are meaningless and the sum is forced to zero.
	assign idx_lo     = IDX_W'((count_q - CNT_W'(1)) >> 1);
	assign idx_hi     = IDX_W'(count_q >> 1);
	assign median_sum = 33'(cell_value[idx_lo]) + 33'(cell_value[idx_hi]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q      <= 1'b0;
			s2_q      <= 1'b0;
			count_q   <= '0;
			status_q  <= ST_DONE;
			rsp_valid <= 1'b0;
		end else begin
			s1_q <= req_accept;

			if (s1_q) begin
				s2_q <= 1'b1;
				if (cmd.ins) begin
					count_q <= count_q + CNT_W'(1);
				end else if (cmd.rem) begin
					count_q <= count_q - CNT_W'(1);
				end
				if (item_s1.action == ACT_INSERT) begin
					status_q <= full ? ST_FULL : ST_DONE;
				end else begin
					status_q <= found ? ST_DONE : ST_ABSENT;
				end
			end else if (s2_q && out_free) begin
				s2_q <= 1'b0;
			end

			if (s2_q && out_free) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			item_s1 <= req;
		end
		if (s2_q && out_free) begin
			rsp.median_twice  <= (count_q != '0) ? median_sum : '0;
			rsp.median_valid  <= (count_q != '0);
			rsp.element_count <= 7'(count_q);
			rsp.status        <= status_q;
		end
	end

	// The store never holds more than its capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count exceeds capacity");

	// The row update and the median step never overlap.
	a_stage_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_q && s2_q))
		else $error("update and median stages both busy");

	// A performed insert raises the count by exactly one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not raise the count by one");

	// A new result only ever comes from a finished median step.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(s2_q))
		else $error("result appeared without a median step");

endmodule

/* bench/tb_running_median_insert_delete_top.sv */
module tb_running_median_insert_delete_top;
	import rmid_pkg::*;

	localparam int ITEMS      = 1450;
	localparam int SHOW_LIMIT = 60;
	localparam int IDLE_PCT   = 29;
	localparam int TAIL       = 8;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	running_median_insert_delete_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	typedef struct {
		req_word_t w;
		bit        typed;
		rsp_word_t exp;
	} probe_row_t;

	// Shadow of the sorted multiset, ascending in cells 0 .. held_total-1.
	logic signed [31:0] held_cells [CAPACITY];
	int                 held_total = 0;

	rsp_word_t  pending_medians [$];
	probe_row_t directed_rows [$];
	int         errors = 0;
	bit         quiet  = 1'b0;

	initial forever #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("** running_median_insert_delete_top: FAILED **");
		$finish;
	end

	// The receiver stalls at random except during the quiet stretch.
	always @(posedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Applies one word to the shadow store and returns the word the block
	// should answer with.
	function automatic rsp_word_t step_median(req_word_t w);
		logic [1:0]         st;
		int                 pos;
		logic signed [32:0] twice;
		rsp_word_t          r;
		st = ST_DONE;
		if (w.action == ACT_INSERT) begin
			if (held_total >= CAPACITY) begin
				st = ST_FULL;
			end else begin
				// Equal values already held stay ahead of the new one.
				pos = 0;
				while (pos < held_total && held_cells[pos] <= w.value) pos++;
				for (int i = held_total; i > pos; i--) held_cells[i] = held_cells[i - 1];
				held_cells[pos] = w.value;
				held_total++;
			end
		end else begin
			pos = 0;
			while (pos < held_total && held_cells[pos] != w.value) pos++;
			if (pos >= held_total) begin
				st = ST_ABSENT;
			end else begin
				for (int i = pos; i + 1 < held_total; i++) held_cells[i] = held_cells[i + 1];
				held_total--;
			end
		end
		twice = '0;
		r.median_valid = 1'b0;
		if (held_total > 0) begin
			twice = held_cells[(held_total - 1) / 2] + held_cells[held_total / 2];
			r.median_valid = 1'b1;
		end
		r.median_twice  = twice;
		r.element_count = 7'(held_total);
		r.status        = st;
		return r;
	endfunction

	function automatic rsp_word_t want(logic signed [32:0] twice, logic valid,
			logic [6:0] count, logic [1:0] st);
		rsp_word_t r;
		r.median_twice  = twice;
		r.median_valid  = valid;
		r.element_count = count;
		r.status        = st;
		return r;
	endfunction

	// Small values collide often, which exercises duplicates; the rest
	// covers the extremes and every bit of the value.
	function automatic logic signed [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30) return $signed(32'($urandom_range(0, 8))) - 32'sd4;
		if (r < 45) begin
			case ($urandom_range(0, 5))
				0: begin
					return 32'sh8000_0000;
				end
				1: begin
					return 32'sh7fff_ffff;
				end
				2: begin
					return 32'sh8000_0001;
				end
				3: begin
					return 32'sh7fff_fffe;
				end
				4: begin
					return 32'sd0;
				end
				default: begin
					return -32'sd1;
				end
			endcase
		end
		return $urandom;
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp);
		errors++;
		if (errors <= SHOW_LIMIT)
			$display("mismatch in %s: got 'h%0h, expected 'h%0h at %0t", what, got, exp, $time);
	endtask

	task automatic add_row(logic act, logic signed [31:0] v, bit typed, rsp_word_t exp);
		probe_row_t row;
		row.w.action = act;
		row.w.value  = v;
		row.typed    = typed;
		row.exp      = exp;
		directed_rows.push_back(row);
	endtask

	// Presents one word, holds it until accepted, then records what the
	// block must answer. The shadow store is touched by this process only.
	task automatic send_word(req_word_t w, bit typed, rsp_word_t exp);
		rsp_word_t pred;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall !== 1'b0);
		pred = step_median(w);
		pending_medians.push_back(typed ? exp : pred);
	endtask

	task automatic drain_wait();
		req_valid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
	endtask

	// Outputs are stable at the falling edge, so the word seen here is the
	// one taken at the next rising edge whenever valid is high and stall low.
	always @(negedge clk) begin
		rsp_word_t exp;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_medians.size() == 0) begin
				flag_mismatch("unexpected word", 64'(rsp), 64'd0);
			end else begin
				exp = pending_medians.pop_front();
				if (rsp.median_twice !== exp.median_twice)
					flag_mismatch("median_twice", 64'(rsp.median_twice), 64'(exp.median_twice));
				if (rsp.median_valid !== exp.median_valid)
					flag_mismatch("median_valid", 64'(rsp.median_valid), 64'(exp.median_valid));
				if (rsp.element_count !== exp.element_count)
					flag_mismatch("element_count", 64'(rsp.element_count), 64'(exp.element_count));
				if (rsp.status !== exp.status)
					flag_mismatch("status", 64'(rsp.status), 64'(exp.status));
			end
		end
	end

	initial begin
		req_word_t w;
		int        sent;
		int        left;
		int        ins_pct;
		int        mode;

		// Extremes and error codes carry a typed answer; 33'sh1_0000_0000 is
		// twice the most negative value.
		add_row(ACT_REMOVE, 32'sd0,          1, want(33'sd0, 1'b0, 7'd0, ST_ABSENT));
		add_row(ACT_INSERT, 32'sh7fff_ffff,  1, want(33'sd4294967294, 1'b1, 7'd1, ST_DONE));
		add_row(ACT_INSERT, 32'sh7fff_ffff,  1, want(33'sd4294967294, 1'b1, 7'd2, ST_DONE));
		add_row(ACT_REMOVE, 32'sh7fff_ffff,  1, want(33'sd4294967294, 1'b1, 7'd1, ST_DONE));
		add_row(ACT_REMOVE, 32'sh7fff_ffff,  1, want(33'sd0, 1'b0, 7'd0, ST_DONE));
		add_row(ACT_REMOVE, 32'sh7fff_ffff,  1, want(33'sd0, 1'b0, 7'd0, ST_ABSENT));
		add_row(ACT_INSERT, 32'sh8000_0000,  1, want(33'sh1_0000_0000, 1'b1, 7'd1, ST_DONE));
		add_row(ACT_INSERT, 32'sh8000_0000,  1, want(33'sh1_0000_0000, 1'b1, 7'd2, ST_DONE));
		add_row(ACT_INSERT, 32'sh7fff_ffff,  1, want(33'sh1_0000_0000, 1'b1, 7'd3, ST_DONE));
		add_row(ACT_INSERT, 32'sh7fff_ffff,  1, want(-33'sd1, 1'b1, 7'd4, ST_DONE));
		add_row(ACT_REMOVE, 32'sd7,          1, want(-33'sd1, 1'b1, 7'd4, ST_ABSENT));
		add_row(ACT_REMOVE, 32'sh8000_0000,  1, want(33'sd4294967294, 1'b1, 7'd3, ST_DONE));
		add_row(ACT_REMOVE, 32'sh7fff_ffff,  1, want(-33'sd1, 1'b1, 7'd2, ST_DONE));
		add_row(ACT_REMOVE, 32'sh7fff_ffff,  1, want(33'sh1_0000_0000, 1'b1, 7'd1, ST_DONE));
		add_row(ACT_REMOVE, 32'sh8000_0000,  1, want(33'sd0, 1'b0, 7'd0, ST_DONE));
		// Duplicates, odd and even counts.
		add_row(ACT_INSERT, 32'sd5,          0, '0);
		add_row(ACT_INSERT, 32'sd5,          0, '0);
		add_row(ACT_INSERT, -32'sd3,         0, '0);
		add_row(ACT_INSERT, 32'sd5,          0, '0);
		add_row(ACT_REMOVE, 32'sd5,          0, '0);
		add_row(ACT_INSERT, 32'sd0,          0, '0);
		add_row(ACT_REMOVE, -32'sd3,         0, '0);
		add_row(ACT_REMOVE, 32'sd5,          0, '0);
		add_row(ACT_INSERT, 32'sh5555_5555,  0, '0);
		add_row(ACT_INSERT, 32'shaaaa_aaaa,  0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].exp);
		drain_wait();

		// Random part in episodes: filling runs aim to reach the full store and push
		// past it, draining runs mostly remove values that are held, and
		// mixed runs wander around the middle.
		sent = 0;
		while (sent < ITEMS) begin
			mode    = $urandom_range(0, 2);
			left    = (mode == 0) ? $urandom_range(60, 150) : $urandom_range(20, 100);
			ins_pct = (mode == 0) ? 90 : (mode == 1) ? 15 : 55;
			while (left > 0 && sent < ITEMS) begin
				quiet <= (sent >= 500 && sent < 800);
				if (sent == 1000) drain_wait();
				if ($urandom_range(0, 99) < ins_pct) begin
					w.action = ACT_INSERT;
					w.value  = pick_value();
				end else begin
					w.action = ACT_REMOVE;
					if (held_total > 0 && $urandom_range(0, 99) < 80)
						w.value = held_cells[$urandom_range(0, held_total - 1)];
					else
						w.value = pick_value();
				end
				send_word(w, 0, '0);
				sent++;
				left--;
			end
		end

		drain_wait();
		repeat (TAIL) @(posedge clk);
		if (errors == 0) begin
			$display("** running_median_insert_delete_top: PASSED **");
		end else begin
			$display("** running_median_insert_delete_top: FAILED **");
		end
		$finish;
	end

endmodule
